// ----- rtl/core/cotc_pkg.sv -----
// shared types and constants for the oven cook timer controller
package cotc_pkg;

   localparam int DIGIT_W   = 4;
   localparam int COUNT_W   = 13;
   localparam int FUNC_W    = 3;
   localparam int MSG_W     = 4;
   localparam int MODE_W    = 2;
   localparam int NUM_DIGITS = 4;

   // digit positions in the mm:ss word
   localparam int DIG_MT = 0;
   localparam int DIG_MU = 1;
   localparam int DIG_ST = 2;
   localparam int DIG_SU = 3;

   localparam logic [COUNT_W-1:0] MAX_SECONDS = COUNT_W'(6000);

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE  = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_PAUSE = 2'd2
   } mode_type;

   typedef enum logic [FUNC_W-1:0] {
      EV_NONE   = 3'd0,
      EV_START  = 3'd1,
      EV_CANCEL = 3'd2,
      EV_DIGIT  = 3'd3,
      EV_TICK   = 3'd4
   } event_type;

   typedef enum logic [MSG_W-1:0] {
      MSG_NONE     = 4'd0,
      MSG_DOOR     = 4'd1,
      MSG_FOOD     = 4'd2,
      MSG_RESET    = 4'd3,
      MSG_DONE     = 4'd4,
      MSG_NOTADJ   = 4'd5,
      MSG_SETTIMER = 4'd6,
      MSG_RUNNING  = 4'd7,
      MSG_PAUSED   = 4'd8
   } msg_type;

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [DIGIT_W-1:0] key_digit;
      logic               door_open;
      logic               food_present;
   } req_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic               power_on;
      logic [MSG_W-1:0]   message;
      logic [COUNT_W-1:0] seconds_left;
      logic [DIGIT_W-1:0] minute_tens;
      logic [DIGIT_W-1:0] minute_units;
      logic [DIGIT_W-1:0] second_tens;
      logic [DIGIT_W-1:0] second_units;
   } rsp_type;

   // canon holds count as canonical mm:ss digits
   typedef struct packed {
      mode_type           mode;
      logic               power;
      digits_type         digits;
      digits_type         canon;
      logic [COUNT_W-1:0] count;
   } state_type;

endpackage

// ----- rtl/core/oven_cook_timer_controller.sv -----
// oven cook timer controller top level: input register, state and result register
// usage:
// req channel takes one control-loop word per cycle unless stalled: an event code
// (none, start, cancel, keypad digit, one-second tick) plus door and food sensor levels
// rsp channel returns one word per request: mode, power drive, message code,
// remaining seconds and the four mm:ss display digits
// path: an accepted word is captured in the input register, and its response is
// loaded into the result register once that register is empty or being read
// throughput: one word per cycle unless rsp stalls; the state update is a single
// pass of combinational logic between the input register and the result register
// reset: idle mode, power off, digits and count zero, both registers empty
// rsp stall: the response holds in the result register; the input register
// still takes one more word, then req_ready drops until rsp_ready returns
module oven_cook_timer_controller
   import cotc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_data_ff;
   state_type state_ff;
   state_type state_step;
   rsp_type   result_step;
   logic      adv;

   cotc_step u_step (
      .item   (in_data_ff),
      .cur    (state_ff),
      .nxt    (state_step),
      .result (result_step)
   );

   assign adv          = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || adv;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !adv);
   assign out_valid_in = adv || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_IDLE, power: 1'b0, digits: '0, canon: '0,
                           count: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (adv) begin
            state_ff <= state_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (adv) begin
         out_data_ff <= result_step;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef NO_ASSERTIONS
   a_power_only_running: assert property (@(posedge clock) disable iff (reset)
      state_ff.power |-> state_ff.mode == MODE_RUN)
      else $error("power on outside running mode");

   a_canon_tracks_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff.count == '0) == (state_ff.canon == '0))
      else $error("display digits out of step with count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= MAX_SECONDS)
      else $error("count above maximum");

   a_adv_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      adv |=> out_valid_ff)
      else $error("processed word produced no response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !adv)
      else $error("response overwritten while stalled");
`endif

endmodule

// ----- rtl/core/cotc_step.sv -----
// next-state and result logic for one control-loop word
module cotc_step
   import cotc_pkg::*;
(
   input  req_type   item,
   input  state_type cur,
   output state_type nxt,
   output rsp_type   result
);

   function automatic digits_type bcd_dec(input digits_type c);
      digits_type r;
      r = c;
      if (c[DIG_SU] != '0) begin
         r[DIG_SU] = c[DIG_SU] - DIGIT_W'(1);
      end else begin
         r[DIG_SU] = DIGIT_W'(9);
         if (c[DIG_ST] != '0) begin
            r[DIG_ST] = c[DIG_ST] - DIGIT_W'(1);
         end else begin
            r[DIG_ST] = DIGIT_W'(5);
            if (c[DIG_MU] != '0) begin
               r[DIG_MU] = c[DIG_MU] - DIGIT_W'(1);
            end else begin
               r[DIG_MU] = DIGIT_W'(9);
               r[DIG_MT] = c[DIG_MT] - DIGIT_W'(1);
            end
         end
      end
      return r;
   endfunction

   logic               tick_go;
   logic [COUNT_W-1:0] cnt_t;
   digits_type         canon_t;
   digits_type         digits_t;
   digits_type         load_digits;
   digits_type         load_canon;
   logic               clamp;
   logic [7:0]         mins;
   logic [6:0]         secs;
   logic [13:0]        total;
   msg_type            msg;

   // tick handling comes first
   always_comb begin
      tick_go  = (item.func == EV_TICK) && cur.power && (cur.count != '0);
      cnt_t    = tick_go ? cur.count - COUNT_W'(1) : cur.count;
      canon_t  = tick_go ? bcd_dec(cur.canon) : cur.canon;
      digits_t = tick_go ? canon_t : cur.digits;
   end

   // start load with seconds clamp
   always_comb begin
      clamp       = digits_t[DIG_ST] >= DIGIT_W'(6);
      load_digits = digits_t;
      if (clamp) begin
         load_digits[DIG_ST] = DIGIT_W'(6);
         load_digits[DIG_SU] = '0;
      end
      mins  = {4'b0, load_digits[DIG_MT]} * 8'd10 + {4'b0, load_digits[DIG_MU]};
      secs  = {3'b0, load_digits[DIG_ST]} * 7'd10 + {3'b0, load_digits[DIG_SU]};
      total = {6'b0, mins} * 14'd60 + {7'b0, secs};
      load_canon = load_digits;
      if (clamp) begin
         load_canon[DIG_ST] = '0;
         load_canon[DIG_SU] = '0;
         if (load_digits[DIG_MU] >= DIGIT_W'(9)) begin
            load_canon[DIG_MU] = '0;
            load_canon[DIG_MT] = load_digits[DIG_MT] + DIGIT_W'(1);
         end else begin
            load_canon[DIG_MU] = load_digits[DIG_MU] + DIGIT_W'(1);
         end
      end
   end

   always_comb begin
      nxt        = cur;
      nxt.count  = cnt_t;
      nxt.canon  = canon_t;
      nxt.digits = digits_t;
      msg        = MSG_NONE;
      unique case (cur.mode)
         MODE_RUN: begin
            if (item.door_open) begin
               nxt.power = 1'b0;
               nxt.mode  = MODE_PAUSE;
               msg       = MSG_DOOR;
            end else if (!item.food_present) begin
               nxt.power = 1'b0;
               nxt.mode  = MODE_PAUSE;
               msg       = MSG_FOOD;
            end else if (cnt_t == '0) begin
               nxt.power  = 1'b0;
               nxt.mode   = MODE_IDLE;
               msg        = MSG_DONE;
               nxt.digits = '0;
               nxt.canon  = '0;
               nxt.count  = '0;
            end else begin
               nxt.power = 1'b1;
               msg       = MSG_RUNNING;
            end
            if (item.func == EV_START) begin
               nxt.mode = MODE_RUN;
            end else if (item.func == EV_CANCEL) begin
               nxt.power = 1'b0;
               nxt.mode  = MODE_PAUSE;
               msg       = MSG_PAUSED;
            end
         end
         MODE_PAUSE: begin
            msg = MSG_PAUSED;
            if (item.func == EV_START) begin
               nxt.mode = MODE_RUN;
               msg      = MSG_RUNNING;
            end else if (item.func == EV_CANCEL) begin
               nxt.digits = '0;
               nxt.canon  = '0;
               nxt.count  = '0;
               nxt.mode   = MODE_IDLE;
               msg        = MSG_RESET;
            end
         end
         default: begin
            nxt.mode = MODE_IDLE;
            msg      = MSG_SETTIMER;
            if (item.func == EV_DIGIT) begin
               if (item.key_digit <= DIGIT_W'(9)) begin
                  nxt.digits[DIG_MT] = digits_t[DIG_MU];
                  nxt.digits[DIG_MU] = digits_t[DIG_ST];
                  nxt.digits[DIG_ST] = digits_t[DIG_SU];
                  nxt.digits[DIG_SU] = item.key_digit;
               end
            end else if (item.func == EV_START) begin
               if (item.door_open) begin
                  msg = MSG_DOOR;
               end else if (!item.food_present) begin
                  msg = MSG_FOOD;
               end else begin
                  nxt.digits = load_digits;
                  nxt.canon  = load_canon;
                  nxt.count  = total[COUNT_W-1:0];
                  if (total[COUNT_W-1:0] == '0) begin
                     msg = MSG_NOTADJ;
                  end else begin
                     nxt.mode = MODE_RUN;
                     msg      = MSG_RUNNING;
                  end
               end
            end else if (item.func == EV_CANCEL) begin
               nxt.digits = '0;
               nxt.canon  = '0;
               nxt.count  = '0;
               msg        = MSG_RESET;
            end
         end
      endcase
   end

   always_comb begin
      result.mode         = nxt.mode;
      result.power_on     = nxt.power;
      result.message      = msg;
      result.seconds_left = nxt.count;
      result.minute_tens  = nxt.digits[DIG_MT];
      result.minute_units = nxt.digits[DIG_MU];
      result.second_tens  = nxt.digits[DIG_ST];
      result.second_units = nxt.digits[DIG_SU];
   end

endmodule
